### rtl/dcnp_pkg.sv
// Shared types, constants and register codes of the depth column nearest point unit.
package dcnp_pkg;

	localparam int IMG_WIDTH_DEF   = 640;
	localparam int IMG_HEIGHT_DEF  = 480;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int POINT_W = 24;
	localparam int DU_W    = 18;
	localparam int DD_W    = DU_W + 17;
	localparam int PROD_W  = DD_W + 25;
	localparam int XC_W    = PROD_W - 20;
	localparam int TERM_W  = 16 + XC_W;
	localparam int ACC_W   = TERM_W + 4;
	localparam int SH_W    = ACC_W - 22;

	localparam logic [31:0] RANGE_RST     = 32'd655360000;
	localparam logic [31:0] HEIGHT_RST    = 32'd131136536;
	localparam logic [31:0] PRINCIPAL_RST = 32'd251663360;
	localparam logic [47:0] INV_FOCAL_RST = 48'd536149523669;
	localparam logic [63:0] ROW_X_RST     = 64'd16384;
	localparam logic [63:0] ROW_Y_RST     = 64'd1073741824;
	localparam logic [63:0] ROW_Z_RST     = 64'd70368744177664;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE     = 3'd0,
		REG_HEIGHT    = 3'd1,
		REG_PRINCIPAL = 3'd2,
		REG_INV_FOCAL = 3'd3,
		REG_ROW_X     = 3'd4,
		REG_ROW_Y     = 3'd5,
		REG_ROW_Z     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [9:0]  col;
		logic [9:0]  u;
		logic [8:0]  v;
		logic [15:0] depth;
		logic        pass;
		logic        last;
	} pix_t;

	typedef struct packed {
		logic [9:0]  col;
		logic [15:0] depth;
		logic        pass;
		logic        last;
	} meta_t;

	typedef struct packed {
		meta_t                      meta;
		logic signed [POINT_W-1:0] px;
		logic signed [POINT_W-1:0] py;
		logic signed [POINT_W-1:0] pz;
	} point_t;

	typedef struct packed {
		logic [15:0]     cx;
		logic [15:0]     cy;
		logic [23:0]     ifx;
		logic [23:0]     ify;
		logic [2:0][63:0] rows;
	} proj_cfg_t;

endpackage

### rtl/dcnp_front.sv
// Front part: takes input items, clamps pixel indexes and applies the depth range test.
module dcnp_front #(
	parameter int IMG_WIDTH  = dcnp_pkg::IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = dcnp_pkg::IMG_HEIGHT_DEF
) (
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [9:0]     column,
	input  logic [8:0]     row,
	input  logic [15:0]    depth_mm,
	input  logic           column_end,
	input  logic [31:0]    range_limits,
	input  logic           queue_full,
	output logic           push,
	output dcnp_pkg::pix_t push_data
);
	import dcnp_pkg::*;

	logic [15:0] rmin;
	logic [15:0] rmax;

	assign rmin = range_limits[15:0];
	assign rmax = range_limits[31:16];

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		push_data.col   = column;
		push_data.u     = (int'(column) > IMG_WIDTH - 1) ? 10'(IMG_WIDTH - 1) : column;
		push_data.v     = (int'(row) > IMG_HEIGHT - 1) ? 9'(IMG_HEIGHT - 1) : row;
		push_data.depth = depth_mm;
		push_data.pass  = (depth_mm != 16'd0) && (depth_mm > rmin) && (depth_mm < rmax);
		push_data.last  = column_end;
	end

endmodule

### rtl/dcnp_queue.sv
// Short item queue between the front part and the projection pipeline.
module dcnp_queue #(
	parameter int DEPTH = dcnp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dcnp_pkg::pix_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output dcnp_pkg::pix_t q_data
);
	import dcnp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pix_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not follow a pop");

endmodule

### rtl/dcnp_project.sv
// Back part: six-stage pipeline that back-projects a pixel and applies the rigid transform.
module dcnp_project (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                q_valid,
	input  dcnp_pkg::pix_t      q_data,
	output logic                pop,
	input  dcnp_pkg::proj_cfg_t cfg,
	output logic                pt_valid,
	output dcnp_pkg::point_t    pt
);
	import dcnp_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;

	logic signed [DU_W-1:0]   du_c;
	logic signed [DU_W-1:0]   dv_c;
	logic signed [DD_W-1:0]   dd_x_s1;
	logic signed [DD_W-1:0]   dd_y_s1;
	logic signed [PROD_W-1:0] prod_x_s2;
	logic signed [PROD_W-1:0] prod_y_s2;
	logic signed [PROD_W-1:0] rnd_x_c;
	logic signed [PROD_W-1:0] rnd_y_c;
	logic signed [XC_W-1:0]   xyz_s3 [3];
	logic signed [TERM_W-1:0] term_s4 [3][3];
	logic signed [ACC_W-1:0]  trans_c [3];
	logic signed [ACC_W-1:0]  acc_s5 [3];
	logic signed [POINT_W-1:0] pnt_s6 [3];

	function automatic logic signed [POINT_W-1:0] sat_point(input logic signed [SH_W-1:0] val);
		logic signed [POINT_W-1:0] res;
		if (val > 8388607) begin
			res = 24'sh7FFFFF;
		end else if (val < -8388608) begin
			res = 24'sh800000;
		end else begin
			res = val[POINT_W-1:0];
		end
		return res;
	endfunction

	assign pop = adv && q_valid;

	always_comb begin
		du_c    = $signed({4'b0, q_data.u, 4'b0}) - $signed({2'b0, cfg.cx});
		dv_c    = $signed({5'b0, q_data.v, 4'b0}) - $signed({2'b0, cfg.cy});
		rnd_x_c = prod_x_s2 + $signed(PROD_W'(1) << 19);
		rnd_y_c = prod_y_s2 + $signed(PROD_W'(1) << 19);
		for (int r = 0; r < 3; r++) begin
			// Translation in mm scaled by 2^22, with the rounding half folded in.
			trans_c[r] = $signed({{(ACC_W - 38){cfg.rows[r][63]}}, cfg.rows[r][63:48],
				1'b1, 21'd0});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= '{col: q_data.col, depth: q_data.depth, pass: q_data.pass,
				last: q_data.last};
			dd_x_s1 <= du_c * $signed({1'b0, q_data.depth});
			dd_y_s1 <= dv_c * $signed({1'b0, q_data.depth});

			meta_s2   <= meta_s1;
			prod_x_s2 <= dd_x_s1 * $signed({1'b0, cfg.ifx});
			prod_y_s2 <= dd_y_s1 * $signed({1'b0, cfg.ify});

			meta_s3   <= meta_s2;
			xyz_s3[0] <= rnd_x_c[PROD_W-1:20];
			xyz_s3[1] <= rnd_y_c[PROD_W-1:20];
			xyz_s3[2] <= $signed({{(XC_W - 24){1'b0}}, meta_s2.depth, 8'b0});

			meta_s4 <= meta_s3;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					term_s4[r][k] <= $signed(cfg.rows[r][16*k +: 16]) * xyz_s3[k];
				end
			end

			meta_s5 <= meta_s4;
			for (int r = 0; r < 3; r++) begin
				acc_s5[r] <= term_s4[r][0] + term_s4[r][1] + term_s4[r][2] + trans_c[r];
			end

			meta_s6 <= meta_s5;
			for (int r = 0; r < 3; r++) begin
				pnt_s6[r] <= sat_point(acc_s5[r][ACC_W-1:22]);
			end
		end
	end

	assign pt_valid = v_s6;
	assign pt.meta  = meta_s6;
	assign pt.px    = pnt_s6[0];
	assign pt.py    = pnt_s6[1];
	assign pt.pz    = pnt_s6[2];

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6}))
		else $error("pipeline moved while stalled");

endmodule

### rtl/dcnp_select.sv
// Back part: keeps the nearest point of the column in height range and holds the result.
module dcnp_select (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pt_valid,
	input  dcnp_pkg::point_t        pt,
	input  logic [31:0]             range_limits,
	input  logic [31:0]             height_limits,
	output logic                    adv,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [9:0]              out_column,
	output logic signed [23:0]      point_x,
	output logic signed [23:0]      point_y,
	output logic signed [23:0]      point_z
);
	import dcnp_pkg::*;

	logic [15:0]               nearest_q;
	logic                      found_q;
	logic signed [POINT_W-1:0] best_x_q;
	logic signed [POINT_W-1:0] best_y_q;
	logic signed [POINT_W-1:0] best_z_q;
	logic                      out_valid_q;
	logic [9:0]                out_column_q;
	logic signed [POINT_W-1:0] out_x_q;
	logic signed [POINT_W-1:0] out_y_q;
	logic signed [POINT_W-1:0] out_z_q;
	logic signed [15:0]        hmin;
	logic signed [15:0]        hmax;
	logic                      take;

	assign hmin = $signed(height_limits[15:0]);
	assign hmax = $signed(height_limits[31:16]);
	assign take = pt.meta.pass && (pt.meta.depth < nearest_q) && (pt.pz >= hmin)
		&& (pt.pz <= hmax);
	assign adv  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nearest_q   <= RANGE_RST[31:16];
			found_q     <= 1'b0;
			best_x_q    <= '0;
			best_y_q    <= '0;
			best_z_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= pt_valid && pt.meta.last && (found_q || take);
			if (pt_valid) begin
				if (pt.meta.last) begin
					nearest_q <= range_limits[31:16];
					found_q   <= 1'b0;
					best_x_q  <= '0;
					best_y_q  <= '0;
					best_z_q  <= '0;
				end else if (take) begin
					nearest_q <= pt.meta.depth;
					found_q   <= 1'b1;
					best_x_q  <= pt.px;
					best_y_q  <= pt.py;
					best_z_q  <= pt.pz;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pt_valid && pt.meta.last) begin
			out_column_q <= pt.meta.col;
			out_x_q      <= take ? pt.px : best_x_q;
			out_y_q      <= take ? pt.py : best_y_q;
			out_z_q      <= take ? pt.pz : best_z_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_column = out_column_q;
	assign point_x    = out_x_q;
	assign point_y    = out_y_q;
	assign point_z    = out_z_q;

	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pt_valid && pt.meta.last))
		else $error("result raised without a column end item");

	a_found_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(found_q) |-> nearest_q == $past(pt.meta.depth))
		else $error("nearest depth not taken from the new point");

endmodule

### rtl/depth_column_nearest_point.sv
// Top level of the depth column nearest point unit with its configuration registers.
// Pixels of one column arrive top to bottom. At the item that carries column_end the unit
// reports the nearest point of that column whose transformed height lies in range, or nothing
// when no pixel of the column qualified. An accepted item goes through a QUEUE_DEPTH-entry
// queue (four by default) and then a six-stage projection pipeline that feeds the result
// register. The unit takes one item per cycle. While a result waits with out_ready low the
// pipeline holds still, and the input stalls once the queue is full. The user must write the
// configuration only while no item is in flight; the block itself does not enforce this.
module depth_column_nearest_point_unit #(
	parameter int IMG_WIDTH   = dcnp_pkg::IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT  = dcnp_pkg::IMG_HEIGHT_DEF,
	parameter int QUEUE_DEPTH = dcnp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [9:0]                      column,
	input  logic [8:0]                      row,
	input  logic [15:0]                     depth_mm,
	input  logic                            column_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [9:0]                      out_column,
	output logic signed [23:0]              point_x,
	output logic signed [23:0]              point_y,
	output logic signed [23:0]              point_z,
	input  logic                            cfg_we,
	input  logic [dcnp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcnp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dcnp_pkg::*;

	logic [31:0] range_q;
	logic [31:0] height_q;
	logic [31:0] principal_q;
	logic [47:0] inv_focal_q;
	logic [63:0] row_x_q;
	logic [63:0] row_y_q;
	logic [63:0] row_z_q;

	proj_cfg_t proj_cfg;
	pix_t      push_data;
	pix_t      q_data;
	point_t    pt;
	logic      push;
	logic      pop;
	logic      queue_full;
	logic      q_valid;
	logic      pt_valid;
	logic      adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q     <= RANGE_RST;
			height_q    <= HEIGHT_RST;
			principal_q <= PRINCIPAL_RST;
			inv_focal_q <= INV_FOCAL_RST;
			row_x_q     <= ROW_X_RST;
			row_y_q     <= ROW_Y_RST;
			row_z_q     <= ROW_Z_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RANGE:     range_q     <= cfg_data[31:0];
				REG_HEIGHT:    height_q    <= cfg_data[31:0];
				REG_PRINCIPAL: principal_q <= cfg_data[31:0];
				REG_INV_FOCAL: inv_focal_q <= cfg_data[47:0];
				REG_ROW_X:     row_x_q     <= cfg_data;
				REG_ROW_Y:     row_y_q     <= cfg_data;
				REG_ROW_Z:     row_z_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		proj_cfg.cx      = principal_q[15:0];
		proj_cfg.cy      = principal_q[31:16];
		proj_cfg.ifx     = inv_focal_q[23:0];
		proj_cfg.ify     = inv_focal_q[47:24];
		proj_cfg.rows[0] = row_x_q;
		proj_cfg.rows[1] = row_y_q;
		proj_cfg.rows[2] = row_z_q;
	end

	dcnp_front #(
		.IMG_WIDTH  (IMG_WIDTH),
		.IMG_HEIGHT (IMG_HEIGHT)
	) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.column       (column),
		.row          (row),
		.depth_mm     (depth_mm),
		.column_end   (column_end),
		.range_limits (range_q),
		.queue_full   (queue_full),
		.push         (push),
		.push_data    (push_data)
	);

	dcnp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	dcnp_project u_project (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.cfg      (proj_cfg),
		.pt_valid (pt_valid),
		.pt       (pt)
	);

	dcnp_select u_select (
		.clk           (clk),
		.arst_n        (arst_n),
		.pt_valid      (pt_valid),
		.pt            (pt),
		.range_limits  (range_q),
		.height_limits (height_q),
		.adv           (adv),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_column    (out_column),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z)
	);

endmodule

### tb/sv/depth_column_nearest_point_checker.sv
// Checker that predicts the nearest point of each depth column and compares the block's results.
module depth_column_nearest_point_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [9:0]                      column,
	input  logic [8:0]                      row,
	input  logic [15:0]                     depth_mm,
	input  logic                            column_end,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [9:0]                      out_column,
	input  logic signed [23:0]              point_x,
	input  logic signed [23:0]              point_y,
	input  logic signed [23:0]              point_z,
	input  logic                            cfg_we,
	input  logic [dcnp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcnp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import dcnp_pkg::*;

	typedef struct {
		logic [9:0]         col;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
	} nearest_pt_t;

	nearest_pt_t        nearest_due[$];
	logic [31:0]        range_lim;
	logic [31:0]        height_lim;
	logic [31:0]        center;
	logic [47:0]        inv_f;
	logic [63:0]        row_x;
	logic [63:0]        row_y;
	logic [63:0]        row_z;
	logic [15:0]        nearest_depth;
	logic signed [23:0] best_x;
	logic signed [23:0] best_y;
	logic signed [23:0] best_z;
	logic               found;
	int                 errs;

	function automatic longint s16(input logic [15:0] h);
		return longint'($signed(h));
	endfunction

	function automatic logic signed [23:0] transform_coord(input logic [63:0] r,
			input longint xc, input longint yc, input longint zc);
		longint acc;
		acc = s16(r[15:0]) * xc + s16(r[31:16]) * yc + s16(r[47:32]) * zc
			+ (s16(r[63:48]) <<< 22);
		acc = (acc + (longint'(1) <<< 21)) >>> 22;
		if (acc > 64'sd8388607)
			return 24'h7FFFFF;
		if (acc < -64'sd8388608)
			return 24'h800000;
		return acc[23:0];
	endfunction

	task automatic column_restart();
		nearest_depth = range_lim[31:16];
		best_x = '0;
		best_y = '0;
		best_z = '0;
		found = 1'b0;
	endtask

	task automatic project_pixel(input logic [9:0] col, input logic [8:0] rw,
			input logic [15:0] d, input logic last);
		longint             u, v, du, dv, xc, yc, zc;
		logic signed [23:0] pz;
		nearest_pt_t        pt;
		u = (col > IMG_WIDTH_DEF - 1) ? IMG_WIDTH_DEF - 1 : col;
		v = (rw > IMG_HEIGHT_DEF - 1) ? IMG_HEIGHT_DEF - 1 : rw;
		if (d != 0 && d > range_lim[15:0] && d < range_lim[31:16]) begin
			du = u * 16 - longint'(center[15:0]);
			dv = v * 16 - longint'(center[31:16]);
			xc = (du * longint'(d) * longint'(inv_f[23:0]) + (longint'(1) <<< 19)) >>> 20;
			yc = (dv * longint'(d) * longint'(inv_f[47:24]) + (longint'(1) <<< 19)) >>> 20;
			zc = longint'(d) * 256;
			pz = transform_coord(row_z, xc, yc, zc);
			if (d < nearest_depth && pz >= s16(height_lim[15:0])
					&& pz <= s16(height_lim[31:16])) begin
				nearest_depth = d;
				best_x = transform_coord(row_x, xc, yc, zc);
				best_y = transform_coord(row_y, xc, yc, zc);
				best_z = pz;
				found = 1'b1;
			end
		end
		if (last) begin
			if (found) begin
				pt.col = col;
				pt.x = best_x;
				pt.y = best_y;
				pt.z = best_z;
				nearest_due.insert(nearest_due.size(), pt);
			end
			column_restart();
		end
	endtask

	task automatic check_point(input logic [9:0] col, input logic signed [23:0] x,
			input logic signed [23:0] y, input logic signed [23:0] z);
		nearest_pt_t want;
		if (nearest_due.size() == 0) begin
			errs++;
			if (errs <= 10)
				$display("Unexpected point: column %0d x %0d y %0d z %0d", col, x, y, z);
		end else begin
			want = nearest_due.pop_front();
			if (want.col !== col || want.x !== x || want.y !== y || want.z !== z) begin
				errs++;
				if (errs <= 10)
					$display("Point mismatch: exp col %0d (%0d,%0d,%0d) got col %0d (%0d,%0d,%0d)",
						want.col, want.x, want.y, want.z, col, x, y, z);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_lim = RANGE_RST;
			height_lim = HEIGHT_RST;
			center = PRINCIPAL_RST;
			inv_f = INV_FOCAL_RST;
			row_x = ROW_X_RST;
			row_y = ROW_Y_RST;
			row_z = ROW_Z_RST;
			column_restart();
			nearest_due.delete();
			errs = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RANGE:     range_lim = cfg_data[31:0];
					REG_HEIGHT:    height_lim = cfg_data[31:0];
					REG_PRINCIPAL: center = cfg_data[31:0];
					REG_INV_FOCAL: inv_f = cfg_data[47:0];
					REG_ROW_X:     row_x = cfg_data;
					REG_ROW_Y:     row_y = cfg_data;
					REG_ROW_Z:     row_z = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				project_pixel(column, row, depth_mm, column_end);
			if (out_valid && out_ready)
				check_point(out_column, point_x, point_y, point_z);
			pending <= nearest_due.size();
			fail_count <= errs;
		end
	end

endmodule

### tb/sv/depth_column_nearest_point_unit_tb.sv
// Testbench top that drives pixels and register settings into the depth column nearest point unit.
module depth_column_nearest_point_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dcnp_pkg::*;

	localparam int CLOCK_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 122;
	localparam int PHASE_COUNT  = 12;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef enum {
		KIND_RESET,
		KIND_PLAIN,
		KIND_WILD,
		KIND_INVERTED,
		KIND_EXT_MAX,
		KIND_EXT_MIN
	} cfg_kind_t;

	typedef struct {
		logic [31:0] range_lim;
		logic [31:0] height_lim;
		logic [31:0] center;
		logic [47:0] inv_f;
		logic [63:0] row_x;
		logic [63:0] row_y;
		logic [63:0] row_z;
	} unit_cfg_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [9:0]            column;
	logic [8:0]            row;
	logic [15:0]           depth_mm;
	logic                  column_end;
	logic                  out_valid;
	logic                  out_ready;
	logic [9:0]            out_column;
	logic signed [23:0]    point_x;
	logic signed [23:0]    point_y;
	logic signed [23:0]    point_z;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;

	bit                    tx_idle_on;
	bit                    rx_idle_on;
	int                    hold_token;
	int                    sent_items;
	logic [15:0]           prev_depth;
	unit_cfg_t             cur_cfg;

	depth_column_nearest_point_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.column     (column),
		.row        (row),
		.depth_mm   (depth_mm),
		.column_end (column_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_column (out_column),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	depth_column_nearest_point_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.column     (column),
		.row        (row),
		.depth_mm   (depth_mm),
		.column_end (column_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_column (out_column),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic int spread(input int n);
		return int'($urandom_range(0, 2 * n)) - n;
	endfunction

	function automatic logic [63:0] pack_row(input int a, input int b, input int c, input int t);
		return {t[15:0], c[15:0], b[15:0], a[15:0]};
	endfunction

	function automatic unit_cfg_t make_cfg(input cfg_kind_t kind);
		unit_cfg_t   c;
		logic [15:0] lo, hi;
		int          h;
		c.range_lim = RANGE_RST;
		c.height_lim = HEIGHT_RST;
		c.center = PRINCIPAL_RST;
		c.inv_f = INV_FOCAL_RST;
		c.row_x = ROW_X_RST;
		c.row_y = ROW_Y_RST;
		c.row_z = ROW_Z_RST;
		case (kind)
			KIND_PLAIN, KIND_INVERTED: begin
				lo = 16'($urandom_range(0, 600));
				hi = 16'($urandom_range(2500, 20000));
				h = -int'($urandom_range(0, 3000));
				c.range_lim = {hi, lo};
				c.height_lim = {16'($urandom_range(800, 30000)), h[15:0]};
				c.center = {16'($urandom_range(0, 7679)), 16'($urandom_range(0, 10239))};
				c.inv_f = {24'($urandom_range(15000, 70000)), 24'($urandom_range(15000, 70000))};
				c.row_x = pack_row(16384 + spread(2000), spread(3000), spread(3000), spread(2000));
				c.row_y = pack_row(spread(3000), 16384 + spread(2000), spread(3000), spread(2000));
				c.row_z = pack_row(spread(3000), spread(3000), 16384 + spread(2000), spread(500));
				if (kind == KIND_INVERTED) begin
					if ($urandom_range(0, 1))
						c.range_lim = {lo, hi};
					else
						c.height_lim = {c.height_lim[15:0], c.height_lim[31:16]};
				end
			end
			KIND_WILD: begin
				c.range_lim = $urandom;
				c.height_lim = $urandom_range(0, 1) ? 32'h7FFF8000 : $urandom;
				c.center = $urandom;
				c.inv_f = {16'($urandom), $urandom};
				c.row_x = {$urandom, $urandom};
				c.row_y = {$urandom, $urandom};
				c.row_z = {$urandom, $urandom};
			end
			KIND_EXT_MAX: begin
				c.range_lim = 32'hFFFF0000;
				c.height_lim = 32'h7FFF8000;
				c.center = 32'hFFFFFFFF;
				c.inv_f = 48'hFFFFFFFFFFFF;
				c.row_x = 64'h7FFF7FFF7FFF7FFF;
				c.row_y = 64'h8000800080008000;
				c.row_z = 64'h00007FFF00000000;
			end
			KIND_EXT_MIN: begin
				c.range_lim = 32'hFFFF0000;
				c.height_lim = 32'h7FFF8000;
				c.center = '0;
				c.inv_f = '0;
				c.row_x = 64'h7FFF000000000000;
				c.row_y = 64'h8000000000000000;
				c.row_z = '0;
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic logic [15:0] pick_depth();
		int lo, hi;
		lo = int'(cur_cfg.range_lim[15:0]);
		hi = int'(cur_cfg.range_lim[31:16]);
		case ($urandom_range(0, 15))
			0: return 16'd0;
			1: return 16'($urandom);
			2: return prev_depth;
			3: return 16'(lo + spread(1));
			4: return 16'(hi + spread(1));
			default:
				if (hi - lo >= 2)
					return 16'($urandom_range(lo + 1, (hi - 1 < lo + 4000) ? hi - 1 : lo + 4000));
				else
					return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_config(input unit_cfg_t c);
		write_reg(REG_RANGE, {$urandom, c.range_lim});
		write_reg(REG_HEIGHT, {$urandom, c.height_lim});
		write_reg(REG_PRINCIPAL, {$urandom, c.center});
		write_reg(REG_INV_FOCAL, {16'($urandom), c.inv_f});
		write_reg(REG_ROW_X, c.row_x);
		write_reg(REG_ROW_Y, c.row_y);
		write_reg(REG_ROW_Z, c.row_z);
		write_reg(REG_SPARE, {$urandom, $urandom});
		cfg_we <= 1'b0;
		cur_cfg = c;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [9:0] c, input logic [8:0] r, input logic [15:0] d,
			input logic last);
		if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		column <= c;
		row <= r;
		depth_mm <= d;
		column_end <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_items++;
		prev_depth = d;
	endtask

	task automatic send_column(input logic [9:0] c, input int len);
		int r;
		r = ($urandom_range(0, 9) == 0) ? $urandom_range(470, 511) : $urandom_range(0, 440);
		for (int i = 0; i < len; i++)
			send_pixel(c, (r + i > 511) ? 9'd511 : 9'(r + i), pick_depth(), i == len - 1);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int seen_hold;
		seen_hold = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != seen_hold) begin
				seen_hold = hold_token;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CLOCK_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		unit_cfg_t c;
		int        target;
		in_valid <= 1'b0;
		column <= '0;
		row <= '0;
		depth_mm <= '0;
		column_end <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		rx_idle_on <= 1'b1;
		hold_token <= 0;
		tx_idle_on = 1'b1;
		sent_items = 0;
		prev_depth = '0;
		cur_cfg = make_cfg(KIND_RESET);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(0, 0, 0, 0);
		send_pixel(0, 1, 1500, 0);
		send_pixel(0, 2, 1500, 0);
		send_pixel(0, 479, 800, 0);
		send_pixel(0, 511, 700, 1);
		send_pixel(1023, 100, 1000, 1);
		send_pixel(5, 5, 65535, 1);
		send_pixel(6, 0, 10000, 0);
		send_pixel(6, 1, 3000, 0);
		send_pixel(6, 2, 1, 1);

		wait_idle();
		load_config(make_cfg(KIND_EXT_MAX));
		send_pixel(0, 0, 16000, 1);
		send_pixel(2, 0, 65535, 1);
		send_pixel(639, 479, 2, 0);
		send_pixel(1023, 511, 1, 1);

		wait_idle();
		load_config(make_cfg(KIND_EXT_MIN));
		send_pixel(4, 7, 3, 1);

		wait_idle();
		load_config(make_cfg(KIND_INVERTED));
		send_pixel(10, 0, 500, 0);
		send_pixel(10, 1, 2000, 1);

		// The depth bound of a column is the range maximum at the previous column end.
		wait_idle();
		c = make_cfg(KIND_RESET);
		c.range_lim = {16'd2000, 16'd0};
		load_config(c);
		send_pixel(20, 0, 100, 1);
		wait_idle();
		c.range_lim = {16'd60000, 16'd0};
		load_config(c);
		send_pixel(21, 0, 5000, 0);
		send_pixel(21, 1, 1500, 1);
		wait_idle();
		c.range_lim = {16'd3000, 16'd0};
		load_config(c);
		send_pixel(22, 0, 5000, 0);
		send_pixel(22, 1, 1800, 1);

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			wait_idle();
			case (ph % 6)
				0, 2:    c = make_cfg(KIND_PLAIN);
				1:       c = make_cfg($urandom_range(0, 1) ? KIND_EXT_MAX : KIND_EXT_MIN);
				3:       c = make_cfg(KIND_RESET);
				4:       c = make_cfg(KIND_WILD);
				default: c = make_cfg(KIND_INVERTED);
			endcase
			load_config(c);
			tx_idle_on = (ph < PHASE_COUNT - 2) && ($urandom_range(0, 3) != 0);
			rx_idle_on <= (ph < PHASE_COUNT - 2) && ($urandom_range(0, 3) != 0);
			target = sent_items + PHASE_ITEMS;
			if (ph == 3) begin
				hold_token <= hold_token + 1;
				for (int k = 0; k < 30; k++)
					send_pixel(10'(k), 9'(k), 16'($urandom_range(200, 1900)), 1'b1);
			end
			while (sent_items < target) begin
				if ($urandom_range(0, 9) == 0)
					send_pixel(10'($urandom), 9'($urandom), 16'($urandom), 1'($urandom));
				else
					send_column(($urandom_range(0, 7) == 0) ? 10'($urandom_range(640, 1023))
						: 10'($urandom_range(0, 639)),
						($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
						: $urandom_range(1, 8));
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### depth_column_nearest_point_unit.f
rtl/dcnp_pkg.sv
rtl/dcnp_front.sv
rtl/dcnp_queue.sv
rtl/dcnp_project.sv
rtl/dcnp_select.sv
rtl/depth_column_nearest_point.sv
tb/sv/depth_column_nearest_point_checker.sv
tb/sv/depth_column_nearest_point_unit_tb.sv
